FILE: design/lmscan_pkg.sv
// Shared types, constants and intensity masks for the LED matrix scan engine.
`default_nettype none

package lmscan_pkg;

    localparam int PLANE_COUNT     = 6;
    localparam int SHIFTS_PER_ROW  = 64;
    localparam int PAIRS_PER_ROW   = 32;
    localparam int FRAME_CYCLE     = 16;
    localparam int ROW_COUNT_DEF   = 32;
    localparam int PLANE_BYTES_DEF = 1024;
    localparam int STORE_W         = PLANE_COUNT * 8;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        EV_SHIFT = 1'b0,
        EV_LATCH = 1'b1
    } event_kind_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [2:0]  plane;
        logic [9:0]  byte_address;
        logic [7:0]  byte_value;
    } in_item_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [4:0]  row_address;
        logic        red_top;
        logic        green_top;
        logic        blue_top;
        logic        red_bottom;
        logic        green_bottom;
        logic        blue_bottom;
        logic        enable_pin_level;
        logic        frame_end;
    } out_item_t;

    // Per-tick scan request handed from the sequencer to the output stage
    typedef struct packed {
        event_kind_t kind;
        logic [4:0]  row_address;
        logic        frame_end;
        logic [7:0]  mask;
    } scan_req_t;

    localparam logic [3:0] LOW_MASK [FRAME_CYCLE] = '{
        4'd1, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4, 4'd4, 4'd8,
        4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd0
    };

    // Bit under test for this weight frame, in the low or high nibble
    function automatic logic [7:0] weight_mask(input logic [3:0] weight,
                                               input logic       high_nibble);
        logic [3:0] m;
        m = LOW_MASK[weight];
        return high_nibble ? {m, 4'b0000} : {4'b0000, m};
    endfunction

endpackage

`default_nettype wire

FILE: design/led_matrix_scan_bit_weighted.sv
// Top level of the bit-weighted LED matrix scan engine.
// Input channel s_*: each transfer is either a frame store write (one byte of one
// colour plane; planes 6 and 7 are dropped) or a scan tick. Writes give no result;
// every tick gives exactly one event on the m_* channel, in order.
// A row is 64 shift events (six colour bits each, low nibble pixel then high
// nibble pixel) followed by one latch event; a 16-frame counter picks the tested
// intensity bit, so bit n is shown 2^n frames and the last frame is dark.
// Pipeline: a tick reads the frame store at its transfer into the read stage; its event is
// then registered on m_* once the output register is free, and offered there. Throughput: one
// item per cycle, back to back, while the receiver keeps up.
// Reset: counters return to row 0, shift 0, weight frame 0, and the frame store
// is swept to zero, one entry per cycle through all PLANE_BYTES entries; s_ready stays
// low during the sweep. A stalled receiver holds m_data; one more tick sits in
// the read stage, then s_ready drops until m_ready returns.
`default_nettype none

module led_matrix_scan_bit_weighted #(
    parameter int ROW_COUNT   = lmscan_pkg::ROW_COUNT_DEF,
    parameter int PLANE_BYTES = lmscan_pkg::PLANE_BYTES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire lmscan_pkg::in_item_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output lmscan_pkg::out_item_t      m_data
);

    localparam int AW = $clog2(PLANE_BYTES);

    logic                            s_xfer;
    logic                            tick;
    logic                            wr_en;
    logic                            clearing;
    logic [AW-1:0]                   wr_addr;
    logic [AW-1:0]                   rd_addr;
    logic [15:0]                     wr_red;
    logic [lmscan_pkg::STORE_W-1:0]  rd_data;
    lmscan_pkg::scan_req_t           req;
    lmscan_pkg::scan_req_t           p1_req_reg;
    logic                            p1_valid_reg, p1_valid_next;
    logic                            p1_adv;
    logic                            m_valid_reg, m_valid_next;
    lmscan_pkg::out_item_t           m_data_reg, m_data_next;
    logic [lmscan_pkg::PLANE_COUNT-1:0] bits;

    assign p1_adv  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clearing && (!p1_valid_reg || p1_adv);
    assign s_xfer  = s_valid && s_ready;
    assign tick    = s_xfer && (s_data.opcode == lmscan_pkg::OP_TICK);
    assign wr_en   = s_xfer && (s_data.opcode == lmscan_pkg::OP_WRITE)
                     && (s_data.plane < 3'(lmscan_pkg::PLANE_COUNT));

    // Reduce the byte address into the plane by restoring subtraction
    always_comb begin
        wr_red = {6'b00_0000, s_data.byte_address};
        for (int k = 3; k >= 0; k--) begin
            if (wr_red >= 16'(PLANE_BYTES << k)) begin
                wr_red = wr_red - 16'(PLANE_BYTES << k);
            end
        end
        wr_addr = wr_red[AW-1:0];
    end

    lmscan_seq #(
        .ROW_COUNT   (ROW_COUNT),
        .PLANE_BYTES (PLANE_BYTES)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick),
        .req     (req),
        .rd_addr (rd_addr)
    );

    lmscan_store #(
        .PLANE_BYTES (PLANE_BYTES)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_plane (s_data.plane),
        .wr_addr  (wr_addr),
        .wr_data  (s_data.byte_value),
        .rd_en    (tick),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (tick) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            p1_req_reg <= req;
        end
    end

    // Test the selected bit of each plane's byte
    always_comb begin
        for (int p = 0; p < lmscan_pkg::PLANE_COUNT; p++) begin
            bits[p] = |(rd_data[p*8 +: 8] & p1_req_reg.mask);
        end
    end

    always_comb begin
        m_data_next                  = m_data_reg;
        m_valid_next                 = m_valid_reg;
        if (p1_adv) begin
            m_valid_next                 = 1'b1;
            m_data_next.event_kind       = p1_req_reg.kind;
            m_data_next.row_address      = p1_req_reg.row_address;
            m_data_next.red_top          = bits[0];
            m_data_next.red_bottom       = bits[1];
            m_data_next.green_top        = bits[2];
            m_data_next.green_bottom     = bits[3];
            m_data_next.blue_top         = bits[4];
            m_data_next.blue_bottom      = bits[5];
            m_data_next.enable_pin_level = (p1_req_reg.kind == lmscan_pkg::EV_LATCH);
            m_data_next.frame_end        = p1_req_reg.frame_end;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: design/lmscan_store.sv
// Six-plane frame store: one row holds the same byte of every plane, cleared after reset.
`default_nettype none

module lmscan_store #(
    parameter int PLANE_BYTES = lmscan_pkg::PLANE_BYTES_DEF,
    localparam int AW = $clog2(PLANE_BYTES)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         wr_en,
    input  wire logic [2:0]                   wr_plane,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [7:0]                   wr_data,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output logic [lmscan_pkg::STORE_W-1:0]    rd_data,
    output logic                              clearing
);

    logic [lmscan_pkg::STORE_W-1:0] mem [PLANE_BYTES];
    logic [lmscan_pkg::STORE_W-1:0] rd_data_reg;
    logic                           clr_active_reg, clr_active_next;
    logic [AW-1:0]                  clr_addr_reg, clr_addr_next;

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(PLANE_BYTES - 1)) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // Clear sweep owns the port; otherwise write one plane's byte lane
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            for (int p = 0; p < lmscan_pkg::PLANE_COUNT; p++) begin
                if (wr_plane == 3'(p)) begin
                    mem[wr_addr][p*8 +: 8] <= wr_data;
                end
            end
        end
    end

    // Hold read data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_active_reg;

endmodule

`default_nettype wire

FILE: design/lmscan_seq.sv
// Scan sequencer: shift index, row and weight frame counters and read address.
`default_nettype none

module lmscan_seq #(
    parameter int ROW_COUNT   = lmscan_pkg::ROW_COUNT_DEF,
    parameter int PLANE_BYTES = lmscan_pkg::PLANE_BYTES_DEF,
    localparam int AW    = $clog2(PLANE_BYTES),
    localparam int ROW_W = $clog2(ROW_COUNT)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 tick,
    output lmscan_pkg::scan_req_t     req,
    output logic [AW-1:0]             rd_addr
);

    logic [6:0]       row_step_reg, row_step_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [3:0]       weight_reg, weight_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [AW:0]      addr_sum;
    logic [AW:0]      base_sum;
    logic [ROW_W+4:0] row_ext;
    logic             last_row;

    assign row_ext  = {5'b0_0000, row_reg};
    assign last_row = (row_reg == ROW_W'(ROW_COUNT - 1));

    // Row base plus column pair, wrapped once into the plane
    always_comb begin
        addr_sum = {1'b0, base_reg} + (AW+1)'(row_step_reg[5:1]);
        if (addr_sum >= (AW+1)'(PLANE_BYTES)) begin
            addr_sum = addr_sum - (AW+1)'(PLANE_BYTES);
        end
        rd_addr = addr_sum[AW-1:0];
    end

    always_comb begin
        req.row_address = row_ext[4:0];
        if (!row_step_reg[6]) begin
            req.kind      = lmscan_pkg::EV_SHIFT;
            req.frame_end = 1'b0;
            req.mask      = lmscan_pkg::weight_mask(weight_reg, row_step_reg[0]);
        end else begin
            req.kind      = lmscan_pkg::EV_LATCH;
            req.frame_end = last_row;
            req.mask      = '0;
        end
    end

    always_comb begin
        row_step_next = row_step_reg;
        row_next      = row_reg;
        weight_next   = weight_reg;
        base_next     = base_reg;
        base_sum      = {1'b0, base_reg} + (AW+1)'(lmscan_pkg::PAIRS_PER_ROW);
        if (base_sum >= (AW+1)'(PLANE_BYTES)) begin
            base_sum = base_sum - (AW+1)'(PLANE_BYTES);
        end
        if (tick) begin
            if (!row_step_reg[6]) begin
                row_step_next = row_step_reg + 7'd1;
            end else begin
                row_step_next = '0;
                if (last_row) begin
                    row_next    = '0;
                    base_next   = '0;
                    weight_next = weight_reg + 4'd1;
                end else begin
                    row_next  = row_reg + ROW_W'(1);
                    base_next = base_sum[AW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_step_reg <= '0;
            row_reg      <= '0;
            weight_reg   <= '0;
            base_reg     <= '0;
        end else begin
            row_step_reg <= row_step_next;
            row_reg      <= row_next;
            weight_reg   <= weight_next;
            base_reg     <= base_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_led_matrix_scan_bit_weighted.sv
// Testbench for the bit-weighted LED matrix scan engine: directed script, random traffic, checks.
`timescale 1ns / 100ps

module tb_led_matrix_scan_bit_weighted;

    localparam int RANDOM_ITEMS = 1420;
    localparam int PRINT_CAP = 40;

    typedef struct {
        lmscan_pkg::in_item_t  item;
        int                    reps;
        bit                    typed;
        lmscan_pkg::out_item_t want;
    } scan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    lmscan_pkg::in_item_t  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    lmscan_pkg::out_item_t m_data;

    // Shadow copy of the scan state
    logic [7:0] pix_store [0:lmscan_pkg::PLANE_COUNT-1][0:lmscan_pkg::PLANE_BYTES_DEF-1];
    logic [6:0] row_step;
    logic [4:0] row_ctr;
    logic [3:0] wframe;

    lmscan_pkg::out_item_t pending_events [$];
    lmscan_pkg::out_item_t exp_event;
    scan_row_t             script [$];
    int                    fail_count;
    int                    events_checked;
    int                    burst_left;
    logic [15:0]           ready_pat;
    logic [5:0]            ready_tick;

    led_matrix_scan_bit_weighted u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb_led_matrix_scan_bit_weighted: FAIL");
        $finish;
    end

    task automatic flag(input string msg);
        if (fail_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            flag($sformatf("event %0d %s got %0d want %0d", events_checked, name, got, want));
        end
    endtask

    // Apply one item to the shadow state; return the scan event a tick produces
    task automatic predict_scan_event(input lmscan_pkg::in_item_t it, output bit made,
                                      output lmscan_pkg::out_item_t ev);
        logic [9:0] addr;
        logic [7:0] m;
        int         wbit;
        ev = '0;
        made = 1'b0;
        if (it.opcode == lmscan_pkg::OP_WRITE) begin
            if (it.plane < 3'(lmscan_pkg::PLANE_COUNT)) begin
                pix_store[it.plane][it.byte_address] = it.byte_value;
            end
        end else begin
            made = 1'b1;
            ev.row_address = row_ctr;
            if (row_step < 7'(lmscan_pkg::SHIFTS_PER_ROW)) begin
                addr = {row_ctr, row_step[5:1]};
                if (wframe == 4'd0) begin
                    wbit = 0;
                end else if (wframe <= 4'd2) begin
                    wbit = 1;
                end else if (wframe <= 4'd6) begin
                    wbit = 2;
                end else if (wframe <= 4'd14) begin
                    wbit = 3;
                end else begin
                    wbit = -1;
                end
                m = (wbit < 0) ? 8'h00 : 8'h01 << (wbit + (row_step[0] ? 4 : 0));
                ev.event_kind   = lmscan_pkg::EV_SHIFT;
                ev.red_top      = |(pix_store[0][addr] & m);
                ev.red_bottom   = |(pix_store[1][addr] & m);
                ev.green_top    = |(pix_store[2][addr] & m);
                ev.green_bottom = |(pix_store[3][addr] & m);
                ev.blue_top     = |(pix_store[4][addr] & m);
                ev.blue_bottom  = |(pix_store[5][addr] & m);
                row_step++;
            end else begin
                ev.event_kind = lmscan_pkg::EV_LATCH;
                ev.enable_pin_level = 1'b1;
                row_step = '0;
                if (row_ctr == 5'(lmscan_pkg::ROW_COUNT_DEF - 1)) begin
                    ev.frame_end = 1'b1;
                    row_ctr = '0;
                    wframe++;
                end else begin
                    row_ctr++;
                end
            end
        end
    endtask

    // Send one item in the current burst, then record what it should produce
    task automatic transfer_item(input lmscan_pkg::in_item_t it, input bit typed,
                                 input lmscan_pkg::out_item_t want);
        bit                    made;
        lmscan_pkg::out_item_t ev;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_scan_event(it, made, ev);
        if (made) begin
            pending_events.push_back(typed ? want : ev);
        end
    endtask

    task automatic add_row(input lmscan_pkg::in_item_t it, input int reps, input bit typed,
                           input lmscan_pkg::out_item_t want);
        script.push_back('{it, reps, typed, want});
    endtask

    // Receiver: stall on a random 16-bit pattern redrawn as ready_tick wraps, or never stall
    always @(posedge aclk) begin
        if (ready_tick == 6'd0) begin
            if ($urandom_range(0, 3) == 0) begin
                ready_pat = 16'hFFFF;
            end else begin
                ready_pat = 16'($urandom) | 16'h0001;
            end
        end
        m_ready <= ready_pat[ready_tick[3:0]];
        ready_tick = ready_tick + 6'd1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                flag($sformatf("event %0d arrived with nothing pending", events_checked));
            end else begin
                exp_event = pending_events.pop_front();
                check_field("event_kind", m_data.event_kind, exp_event.event_kind);
                check_field("row_address", m_data.row_address, exp_event.row_address);
                check_field("red_top", m_data.red_top, exp_event.red_top);
                check_field("green_top", m_data.green_top, exp_event.green_top);
                check_field("blue_top", m_data.blue_top, exp_event.blue_top);
                check_field("red_bottom", m_data.red_bottom, exp_event.red_bottom);
                check_field("green_bottom", m_data.green_bottom, exp_event.green_bottom);
                check_field("blue_bottom", m_data.blue_bottom, exp_event.blue_bottom);
                check_field("enable_pin_level", m_data.enable_pin_level,
                            exp_event.enable_pin_level);
                check_field("frame_end", m_data.frame_end, exp_event.frame_end);
            end
            events_checked++;
        end
    end

    initial begin
        lmscan_pkg::in_item_t it;
        logic [4:0]           pair;
        int                   n;
        int                   r;

        fail_count = 0;
        events_checked = 0;
        burst_left = 0;
        ready_pat = 16'hFFFF;
        ready_tick = '0;
        row_step = '0;
        row_ctr = '0;
        wframe = '0;
        for (int p = 0; p < lmscan_pkg::PLANE_COUNT; p++) begin
            for (int a = 0; a < lmscan_pkg::PLANE_BYTES_DEF; a++) begin
                pix_store[p][a] = '0;
            end
        end

        // Directed script; steps within row 0 are tracked in the comments
        // step 0: store just cleared, so no colour bit is lit
        add_row({lmscan_pkg::OP_TICK, 3'd7, 10'd1023, 8'hFF}, 1, 1'b1,
                {lmscan_pkg::EV_SHIFT, 5'd0, 6'b000000, 1'b0, 1'b0});
        for (int p = 0; p < lmscan_pkg::PLANE_COUNT; p++) begin
            add_row({lmscan_pkg::OP_WRITE, 3'(p), 10'd0, 8'hFF}, 1, 1'b0, '0);
        end
        // step 1: high pixel of pair 0 lit in every plane
        add_row({lmscan_pkg::OP_TICK, 3'd0, 10'd0, 8'h00}, 1, 1'b1,
                {lmscan_pkg::EV_SHIFT, 5'd0, 6'b111111, 1'b0, 1'b0});
        // writes to planes 6 and 7 must be dropped
        add_row({lmscan_pkg::OP_WRITE, 3'd6, 10'd1, 8'hFF}, 1, 1'b0, '0);
        add_row({lmscan_pkg::OP_WRITE, 3'd7, 10'd1, 8'hFF}, 1, 1'b0, '0);
        add_row({lmscan_pkg::OP_WRITE, 3'd1, 10'd1, 8'h01}, 1, 1'b0, '0);
        // step 2: low pixel of pair 1, only red bottom has bit 0 set
        add_row({lmscan_pkg::OP_TICK, 3'd5, 10'd512, 8'h5A}, 1, 1'b1,
                {lmscan_pkg::EV_SHIFT, 5'd0, 6'b000100, 1'b0, 1'b0});
        add_row({lmscan_pkg::OP_WRITE, 3'd4, 10'd1, 8'hE0}, 1, 1'b0, '0);
        // step 3: high pixel of pair 1 has no bit 0 anywhere
        add_row({lmscan_pkg::OP_TICK, 3'd2, 10'd341, 8'hA5}, 1, 1'b1,
                {lmscan_pkg::EV_SHIFT, 5'd0, 6'b000000, 1'b0, 1'b0});
        add_row({lmscan_pkg::OP_WRITE, 3'd5, 10'd1023, 8'hAA}, 1, 1'b0, '0);
        add_row({lmscan_pkg::OP_WRITE, 3'd2, 10'd2, 8'h55}, 1, 1'b0, '0);
        add_row({lmscan_pkg::OP_WRITE, 3'd3, 10'd3, 8'h0F}, 1, 1'b0, '0);
        add_row({lmscan_pkg::OP_TICK, 3'd3, 10'd682, 8'h33},
                lmscan_pkg::SHIFTS_PER_ROW - 4, 1'b0, '0);
        add_row({lmscan_pkg::OP_TICK, 3'd1, 10'd0, 8'hCC}, 1, 1'b1,
                {lmscan_pkg::EV_LATCH, 5'd0, 6'b000000, 1'b1, 1'b0});
        add_row({lmscan_pkg::OP_TICK, 3'd4, 10'd1023, 8'h00}, 1, 1'b1,
                {lmscan_pkg::EV_SHIFT, 5'd1, 6'b000000, 1'b0, 1'b0});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            repeat (script[i].reps) begin
                transfer_item(script[i].item, script[i].typed, script[i].want);
            end
        end

        // Mixed traffic of writes and ticks
        n = 0;
        while (n < RANDOM_ITEMS) begin
            it = lmscan_pkg::in_item_t'($urandom);
            if ($urandom_range(0, 99) < 50) begin
                it.opcode = lmscan_pkg::OP_TICK;
            end else begin
                it.opcode = lmscan_pkg::OP_WRITE;
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    it.plane = 3'($urandom_range(lmscan_pkg::PLANE_COUNT, 7));
                end else begin
                    it.plane = 3'($urandom_range(0, lmscan_pkg::PLANE_COUNT - 1));
                    // aim most writes just ahead of the scan position
                    if (r > 2) begin
                        pair = row_step[5:1] + 5'($urandom_range(0, 3));
                        it.byte_address = {row_ctr, pair};
                    end
                end
            end
            transfer_item(it, 1'b0, '0);
            n++;
        end
        s_valid <= 1'b0;

        while (pending_events.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (fail_count == 0) begin
            $display("tb_led_matrix_scan_bit_weighted: PASS");
        end else begin
            $display("tb_led_matrix_scan_bit_weighted: FAIL");
        end
        $finish;
    end

endmodule
